### hdl/debounced_multitap_keypad_decoder_macros.svh
// Assertion macros for the keypad decoder.
`ifndef DEBOUNCED_MULTITAP_KEYPAD_DECODER_MACROS_SVH
`define DEBOUNCED_MULTITAP_KEYPAD_DECODER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DMK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define DMK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hdl/dmk_pkg.sv
// Package: shared types, constants and character tables of the keypad decoder.
package dmk_pkg;
  localparam logic [15:0] WindowReset = 16'd500;
  localparam logic [3:0]  NoneButton  = 4'd13;
  localparam logic [3:0]  ShiftButton = 4'd10;

  typedef enum logic [2:0] {
    EvBack = 3'd0, EvChar = 3'd1, EvUp = 3'd2, EvDown = 3'd3,
    EvLeft = 3'd4, EvRight = 3'd5, EvSelect = 3'd6, EvCancel = 3'd7
  } event_kind_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  ch;
    logic [10:0] cp;
  } event_t;

  typedef struct packed {
    logic   [1:0] cnt;
    event_t       e0;
    event_t       e1;
  } result_t;

  function automatic logic [6:0] latin_char(input logic [1:0] lvl, input logic [1:0] tap,
                                            input logic [3:0] btn);
    logic [6:0] c;
    c = 7'h20;
    if (lvl == 2'd2) begin
      c = (btn == 4'd9) ? 7'h30 : 7'(7'h31 + btn);
    end else if (btn == 4'd9) begin
      c = 7'h20;
    end else if (tap == 2'd3) begin
      case (btn)
        4'd0: c = 7'h31;
        4'd1: c = 7'h32;
        4'd2: c = 7'h33;
        4'd3: c = 7'h34;
        4'd4: c = 7'h35;
        4'd5: c = 7'h36;
        4'd6: c = (lvl == 2'd0) ? 7'h73 : 7'h53;
        4'd7: c = 7'h38;
        default: c = (lvl == 2'd0) ? 7'h7a : 7'h5a;
      endcase
    end else if (btn == 4'd0) begin
      case (tap)
        2'd0: c = (lvl == 2'd0) ? 7'h2e : 7'h21;
        2'd1: c = (lvl == 2'd0) ? 7'h2c : 7'h2b;
        default: c = (lvl == 2'd0) ? 7'h3f : 7'h2d;
      endcase
    end else begin
      c = 7'(((lvl == 2'd0) ? 7'h61 : 7'h41) + ((7'(btn) - 7'd1) * 7'd3) + 7'(tap));
      if (btn >= 4'd7) c = 7'(c + 7'd1);
    end
    return c;
  endfunction

  function automatic logic [10:0] cyr_char(input logic lvl, input logic [1:0] tap,
                                           input logic [3:0] btn);
    logic [10:0] base;
    base = lvl ? 11'h410 : 11'h430;
    if (btn == 4'd9) return 11'd0;
    if (btn == 4'd0) begin
      if (tap != 2'd3) return 11'd0;
      return lvl ? 11'h401 : 11'h451;
    end
    return 11'(base + ((11'(btn) - 11'd1) * 11'd4) + 11'(tap));
  endfunction
endpackage

### hdl/dmk_core.sv
// Decode logic: debounce, edge detect, priority resolve and character lookup.
module dmk_core import dmk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [15:0] sample_i,
  input  logic [31:0] now_i,
  input  logic [15:0] window_i,
  output result_t     res_o
);
  logic [15:0] pend_q, stab_q;
  logic        settled_q, cyr_q;
  logic [1:0]  lvl_q, saved_q, tap_q;
  logic [3:0]  prev_q;
  logic [31:0] ptime_q;

  logic [15:0] pend_d, stab_d, pressed, newly;
  logic        settled_d, cyr_d, in_win, sh, act;
  logic [1:0]  lvl_d, saved_d, tap_d, lvl, tapw, tapn;
  logic [3:0]  prev_d, btn;
  logic [31:0] ptime_d, el;
  logic [10:0] cp, cyc;
  logic [6:0]  lc;
  logic        rep;

  always_comb begin
    pend_d = pend_q; stab_d = stab_q; settled_d = settled_q; cyr_d = cyr_q;
    lvl_d = lvl_q; saved_d = saved_q; tap_d = tap_q; prev_d = prev_q; ptime_d = ptime_q;
    res_o = '0;
    pressed = ~sample_i;
    newly = pressed & stab_q;
    lvl = (lvl_q == 2'd3) ? 2'd2 : lvl_q;
    el = now_i - ptime_q;
    in_win = el < {16'd0, window_i};
    tapw = in_win ? tap_q : 2'd0;
    sh = pressed[8];
    btn = NoneButton;
    act = 1'b0;
    rep = 1'b0; tapn = tapw; cp = '0; cyc = '0; lc = '0;
    if (go_i) begin
      if (sample_i != pend_q) pend_d = sample_i;
      else if (sample_i == 16'h0000) settled_d = 1'b0;
      else if (!settled_q) begin
        if (sample_i == 16'hFFFF) begin settled_d = 1'b1; stab_d = sample_i; end
      end else if (sample_i != stab_q) begin
        stab_d = sample_i;
        act = newly != 16'd0;
      end
    end
    if (act) begin
      lvl_d = lvl; tap_d = tapw;
      if (sh && newly[9]) begin
        cyr_d = ~cyr_q; lvl_d = saved_q; tap_d = 2'd0; prev_d = NoneButton;
      end else begin
        if (newly[13]) begin
          res_o.cnt = 2'd1;
          res_o.e0.kind = sh ? EvUp : EvLeft;
          if (sh) lvl_d = saved_q;
        end else if (newly[14]) begin
          res_o.cnt = 2'd1;
          res_o.e0.kind = sh ? EvDown : EvRight;
          if (sh) lvl_d = saved_q;
        end else if (newly[15]) begin
          res_o.cnt = 2'd1; res_o.e0.kind = EvSelect;
        end else if (newly[12]) begin
          res_o.cnt = 2'd1; res_o.e0.kind = EvCancel;
        end else if (newly[7]) btn = 4'd0;
        else if (newly[6]) btn = 4'd1;
        else if (newly[5]) btn = 4'd2;
        else if (newly[4]) btn = 4'd3;
        else if (newly[3]) btn = 4'd4;
        else if (newly[10]) btn = 4'd5;
        else if (newly[11]) btn = 4'd6;
        else if (newly[0]) btn = 4'd7;
        else if (newly[1]) btn = 4'd8;
        else if (newly[9]) btn = 4'd9;
        else if (newly[2]) begin
          res_o.cnt = 2'd1;
          if (sh) begin
            res_o.e0.kind = EvChar; res_o.e0.ch = 7'd9; lvl_d = saved_q;
          end else begin
            res_o.e0.kind = EvBack; res_o.e0.ch = 7'd8;
          end
        end else if (newly[8]) btn = ShiftButton;

        if (btn != NoneButton) begin
          rep = (btn == prev_q) && in_win;
          if (rep) tapn = 2'(tapw + 2'd1);
          if (btn != prev_q) tapn = 2'd0;
          tap_d = tapn;
          ptime_d = now_i;
          prev_d = btn;
          if (btn == ShiftButton) begin
            saved_d = lvl;
            lvl_d = (lvl == 2'd2) ? 2'd0 : 2'(lvl + 2'd1);
          end else begin
            cyc = (cyr_q && lvl != 2'd2) ? cyr_char(lvl[0], tapn, btn) : 11'd0;
            lc = latin_char(lvl, tapn, btn);
            cp = (cyc != 11'd0) ? cyc : {4'd0, lc};
            if (rep) begin
              res_o.cnt = 2'd2;
              res_o.e0.kind = EvBack; res_o.e0.ch = 7'd8;
              res_o.e1.kind = EvChar;
              if (cp < 11'h80) res_o.e1.ch = cp[6:0]; else res_o.e1.cp = cp;
            end else begin
              res_o.cnt = 2'd1;
              res_o.e0.kind = EvChar;
              if (cp < 11'h80) res_o.e0.ch = cp[6:0]; else res_o.e0.cp = cp;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0; stab_q <= 16'hFFFF; settled_q <= 1'b0; cyr_q <= 1'b0;
      lvl_q <= '0; saved_q <= '0; tap_q <= '0; prev_q <= NoneButton; ptime_q <= '0;
    end else begin
      pend_q <= pend_d; stab_q <= stab_d; settled_q <= settled_d; cyr_q <= cyr_d;
      lvl_q <= lvl_d; saved_q <= saved_d; tap_q <= tap_d; prev_q <= prev_d;
      ptime_q <= ptime_d;
    end
  end

`include "debounced_multitap_keypad_decoder_macros.svh"
  `DMK_ASSERT_IMPL(a_lvl_range, 1'b1, lvl_q != 2'd3, "shift level out of range")
  `DMK_ASSERT_IMPL(a_no_res_idle, !go_i, res_o.cnt == 2'd0, "result without poll")
  `DMK_ASSERT_IMPL(a_two_is_repeat, res_o.cnt == 2'd2, res_o.e0.kind == EvBack,
                   "double result must start with erase")
endmodule

### hdl/debounced_multitap_keypad_decoder.sv
// Top level: keypad decoder with input/output staging and APB register.
// Each accepted poll of the 16-key switch word is registered, then decoded by
// one pass of logic into zero, one or two events held in a two-entry output
// buffer that is loaded only when empty. A poll is taken while the buffer is
// empty after this cycle's drain and the poll now in decode yields no event, so
// polls with no event stream at one per cycle, while after a poll with events the
// next is taken no sooner than its last event pops, so output stalls hold it off.
// The multi-tap window sits at byte address 0 (reset 500 ms) and reads back over
// APB.
module debounced_multitap_keypad_decoder import dmk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  high_byte_i,
  input  logic [7:0]  low_byte_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [6:0]  ascii_char_o,
  output logic [10:0] code_point_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] win_q;
  logic        iv_q;
  logic [15:0] is_q;
  logic [31:0] it_q;
  result_t     res;
  event_t      buf_q [2];
  logic        bl_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        take, pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {16'd0, win_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) win_q <= WindowReset;
    else if (psel && penable && pwrite && paddr == 1'b0) win_q <= pwdata[15:0];
  end

  // Stall unless the buffer is empty after this cycle's drain and the poll in
  // decode loads nothing into it.
  assign pop = out_valid_o && !out_stall_i;
  assign in_stall_o = (cnt_q - 2'(pop)) != 2'd0 || (iv_q && res.cnt != 2'd0);
  assign take = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iv_q <= 1'b0;
    else iv_q <= take;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      is_q <= {high_byte_i, low_byte_i};
      it_q <= now_ms_i;
    end
  end

  dmk_core u_core (
    .clk_i, .rst_ni, .go_i(iv_q), .sample_i(is_q), .now_i(it_q),
    .window_i(win_q), .res_o(res)
  );

  // Load new events into an empty buffer, else shift out one beat per pop.
  always_comb begin
    cnt_d = cnt_q - 2'(pop);
    if (iv_q) cnt_d = res.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (iv_q) begin
      buf_q[0] <= res.e0; bl_q[0] <= res.cnt == 2'd1;
      buf_q[1] <= res.e1; bl_q[1] <= 1'b1;
    end else if (pop) begin
      buf_q[0] <= buf_q[1]; bl_q[0] <= bl_q[1];
    end
  end

  assign out_valid_o   = cnt_q != 2'd0;
  assign event_kind_o  = buf_q[0].kind;
  assign ascii_char_o  = buf_q[0].ch;
  assign code_point_o  = buf_q[0].cp;
  assign last_of_run_o = bl_q[0];

`include "debounced_multitap_keypad_decoder_macros.svh"
  `DMK_ASSERT_IMPL(a_no_take_busy, take, cnt_q <= 2'd1 && (!iv_q || res.cnt == 2'd0),
                   "poll taken with busy buffer")
  `DMK_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_q != 2'd3, "event count overflow")
  `DMK_ASSERT_NEXT(a_load_empty, iv_q, $past(cnt_q) == 2'd0 || $past(pop) && $past(cnt_q) == 2'd1,
                   "decode result overwrote pending events")
endmodule
